[rtl/pcc_pkg.sv]
// Shared types and constants for the polygon point containment block.
// No dependencies; used by pcc_edge_unit and polygon_point_containment.
package pcc_pkg;

  localparam int unsigned MaxVertices = 64;
  localparam int unsigned AddrW       = $clog2(MaxVertices);
  localparam int unsigned CntW        = $clog2(MaxVertices + 1);
  localparam int unsigned CountW      = 7;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_e;

  typedef struct packed {
    logic signed [15:0] y;
    logic signed [15:0] x;
  } vertex_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [15:0] px;
    logic signed [15:0] py;
  } pcc_in_t;

  typedef struct packed {
    logic              inside_res;
    logic              on_boundary;
    logic              accepted;
    logic [CountW-1:0] vertex_count;
  } pcc_out_t;

  typedef struct packed {
    logic    valid;
    logic    last;
    vertex_t a;
    vertex_t b;
  } edge_in_t;

  typedef struct packed {
    logic valid;
    logic last;
    logic boundary;
    logic crossing;
  } edge_res_t;

endpackage

[rtl/pcc_edge_unit.sv]
// Two-stage edge test: one polygon edge against the query point per cycle.
// Depends on pcc_pkg for the vertex and edge beat types.
module pcc_edge_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pcc_pkg::edge_in_t  edge_i,
  input  pcc_pkg::vertex_t   pt_i,
  output pcc_pkg::edge_res_t res_o
);

  logic signed [16:0] x1, y1, x2, y2, px, py;
  logic signed [16:0] lo, hi, ylo, yhi, dx, dy, dyp, dxp;
  logic signed [33:0] p1, p2;
  logic               vert, vbnd, in_span, lt_hi;

  always_comb begin
    x1  = {edge_i.a.x[15], edge_i.a.x};
    y1  = {edge_i.a.y[15], edge_i.a.y};
    x2  = {edge_i.b.x[15], edge_i.b.x};
    y2  = {edge_i.b.y[15], edge_i.b.y};
    px  = {pt_i.x[15], pt_i.x};
    py  = {pt_i.y[15], pt_i.y};
    lo  = (x1 < x2) ? x1 : x2;
    hi  = (x1 < x2) ? x2 : x1;
    ylo = (y1 < y2) ? y1 : y2;
    yhi = (y1 < y2) ? y2 : y1;
    dx  = x2 - x1;
    dy  = y2 - y1;
    dyp = y1 - py;
    dxp = px - x1;
    vert    = (x1 == x2);
    vbnd    = (px == x1) && (py >= ylo) && (py <= yhi);
    in_span = (px >= lo) && (px <= hi);
    lt_hi   = (px < hi);
    // cross products: edge height at px minus py, scaled by dx
    p1 = dyp * dx;
    p2 = dxp * dy;
  end

  // stage one: products and span flags
  logic               s1_valid_q, s1_last_q;
  logic               s1_vert_q, s1_vbnd_q, s1_span_q, s1_lthi_q, s1_dxneg_q;
  logic signed [33:0] s1_p1_q, s1_p2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= edge_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_last_q  <= edge_i.last;
    s1_vert_q  <= vert;
    s1_vbnd_q  <= vbnd;
    s1_span_q  <= in_span;
    s1_lthi_q  <= lt_hi;
    s1_dxneg_q <= dx[16];
    s1_p1_q    <= p1;
    s1_p2_q    <= p2;
  end

  // stage two: sign of the sum decides boundary and crossing for non-vertical edges
  logic signed [34:0] num;
  logic               num_zero, num_pos;
  pcc_pkg::edge_res_t res_d, res_q;

  always_comb begin
    num      = {s1_p1_q[33], s1_p1_q} + {s1_p2_q[33], s1_p2_q};
    num_zero = (num == '0);
    num_pos  = !num[34] && !num_zero;
    res_d.valid    = s1_valid_q;
    res_d.last     = s1_last_q;
    res_d.boundary = s1_vert_q ? s1_vbnd_q : (s1_span_q && num_zero);
    res_d.crossing = !s1_vert_q && s1_span_q && !num_zero && s1_lthi_q
                     && (num_pos == !s1_dxneg_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

[rtl/polygon_point_containment.sv]
// Even-odd point-in-polygon block: vertex store, command sequencer, result register.
// Depends on pcc_pkg and instantiates pcc_edge_unit.

// A start or add command, and a query on an empty polygon, is taken while idle and its
// result strobes on done_o in the following cycle; busy stays low throughout. A query on
// N stored vertices keeps busy high through the read, close, wrap and wait states and
// strobes its result in the cycle after: the vertex store has one read port and the edge
// unit takes one edge per cycle, the closing edge back to the first vertex included,
// followed by its two pipeline stages. Results are not held: done_o is high for one
// cycle only and the receiver must take the beat then.
module polygon_point_containment (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  pcc_pkg::pcc_in_t  item_i,
  output logic              done_o,
  output pcc_pkg::pcc_out_t res_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READ  = 3'd1;
  localparam logic [2:0] ST_CLOSE = 3'd2;
  localparam logic [2:0] ST_WRAP  = 3'd3;
  localparam logic [2:0] ST_WAIT  = 3'd4;

  logic [2:0] state_q, state_d;
  logic [pcc_pkg::CntW-1:0] total_q, total_d, iss_q, iss_d;
  logic rd_v_q, rd_first_q;
  logic par_q, par_d, bnd_q, bnd_d;
  logic done_q, done_d;
  pcc_pkg::pcc_out_t res_q, res_d;
  pcc_pkg::vertex_t pt_q, first_q, prev_q, rdata_q, new_v;
  logic accept, wr_en;
  logic [pcc_pkg::AddrW-1:0] wr_addr;

  pcc_pkg::vertex_t mem_q [pcc_pkg::MaxVertices];

  pcc_pkg::edge_in_t  edge_in;
  pcc_pkg::edge_res_t edge_res;

  assign accept  = start && !busy;
  assign new_v.x = item_i.px;
  assign new_v.y = item_i.py;

  // vertex store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= new_v;
    end
    rdata_q <= mem_q[iss_q[pcc_pkg::AddrW-1:0]];
  end

  always_comb begin
    state_d = state_q;
    total_d = total_q;
    iss_d   = iss_q;
    par_d   = par_q;
    bnd_d   = bnd_q;
    done_d  = 1'b0;
    res_d   = res_q;
    wr_en   = 1'b0;
    wr_addr = total_q[pcc_pkg::AddrW-1:0];

    // fold each edge beat into the running parity and boundary flag
    if (edge_res.valid) begin
      par_d = par_q ^ edge_res.crossing;
      bnd_d = bnd_q | edge_res.boundary;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_d.inside_res  = 1'b0;
          res_d.on_boundary = 1'b0;
          res_d.accepted    = 1'b0;
          priority if (item_i.cmd == pcc_pkg::CMD_START) begin
            wr_en          = 1'b1;
            wr_addr        = '0;
            total_d        = pcc_pkg::CntW'(1);
            res_d.accepted = 1'b1;
            done_d         = 1'b1;
          end else if (item_i.cmd == pcc_pkg::CMD_ADD) begin
            if (total_q < pcc_pkg::CntW'(pcc_pkg::MaxVertices)) begin
              wr_en          = 1'b1;
              total_d        = total_q + 1'b1;
              res_d.accepted = 1'b1;
            end
            done_d = 1'b1;
          end else if (item_i.cmd == pcc_pkg::CMD_QUERY) begin
            if (total_q == '0) begin
              done_d = 1'b1;
            end else begin
              iss_d   = '0;
              par_d   = 1'b0;
              bnd_d   = 1'b0;
              state_d = ST_READ;
            end
          end else begin
            done_d = 1'b1;
          end
          res_d.vertex_count = pcc_pkg::CountW'(total_d);
        end
      end
      ST_READ: begin
        iss_d = iss_q + 1'b1;
        if (iss_d == total_q) begin
          state_d = ST_CLOSE;
        end
      end
      ST_CLOSE: state_d = ST_WRAP;
      ST_WRAP:  state_d = ST_WAIT;
      ST_WAIT: begin
        if (edge_res.valid && edge_res.last) begin
          res_d.on_boundary  = bnd_d;
          res_d.inside_res   = bnd_d | par_d;
          res_d.accepted     = 1'b0;
          res_d.vertex_count = pcc_pkg::CountW'(total_q);
          done_d             = 1'b1;
          state_d            = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // read beat pairs with the previous vertex; the closing edge wraps to the first
  always_comb begin
    edge_in.valid = (rd_v_q && !rd_first_q) || (state_q == ST_WRAP);
    edge_in.last  = (state_q == ST_WRAP);
    edge_in.a     = prev_q;
    edge_in.b     = (state_q == ST_WRAP) ? first_q : rdata_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      total_q    <= '0;
      iss_q      <= '0;
      rd_v_q     <= 1'b0;
      rd_first_q <= 1'b0;
      par_q      <= 1'b0;
      bnd_q      <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      total_q    <= total_d;
      iss_q      <= iss_d;
      rd_v_q     <= (state_q == ST_READ);
      rd_first_q <= (iss_q == '0);
      par_q      <= par_d;
      bnd_q      <= bnd_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (accept) begin
      pt_q.x <= item_i.px;
      pt_q.y <= item_i.py;
    end
    if (rd_v_q) begin
      prev_q <= rdata_q;
      if (rd_first_q) begin
        first_q <= rdata_q;
      end
    end
  end

  pcc_edge_unit u_edge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .edge_i (edge_in),
    .pt_i   (pt_q),
    .res_o  (edge_res)
  );

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

[bench/polygon_point_containment_test.sv]
// Self-checking bench for polygon_point_containment: directed table, then random polygons.
// Depends on pcc_pkg and the polygon_point_containment RTL; results checked against a local
// even-odd crossing predictor, or against the table's expected values for typed rows.
`timescale 1ns / 100ps

module polygon_point_containment_test;

  localparam logic [1:0] CmdUnused = 2'd3;
  localparam int RandomItems = 1500;
  localparam int SettleCycles = 80;

  typedef enum {SPAN_SMALL, SPAN_FULL, SPAN_EXTREME} span_e;

  typedef struct {
    pcc_pkg::pcc_in_t  item;
    bit                typed;
    pcc_pkg::pcc_out_t want;
  } plan_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start;
  logic              busy;
  pcc_pkg::pcc_in_t  item_i;
  logic              done_o;
  pcc_pkg::pcc_out_t res_o;

  pcc_pkg::vertex_t  poly [pcc_pkg::MaxVertices];
  int                poly_len;
  pcc_pkg::pcc_out_t pending_replies [$];
  pcc_pkg::pcc_out_t reply_r;
  plan_row_t         plan [$];
  int                sent_items;
  int                mismatches;

  polygon_point_containment dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .item_i (item_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // bit 1: point on the edge, bit 0: edge crosses the ray above the point
  function automatic logic [1:0] edge_hits(input pcc_pkg::vertex_t a, input pcc_pkg::vertex_t b,
                                           input longint qx, input longint qy);
    longint x1, y1, x2, y2, lo, hi, ylo, yhi, dx, num;
    x1 = $signed(a.x);
    y1 = $signed(a.y);
    x2 = $signed(b.x);
    y2 = $signed(b.y);
    lo = (x1 < x2) ? x1 : x2;
    hi = (x1 < x2) ? x2 : x1;
    if (lo == hi) begin
      ylo = (y1 < y2) ? y1 : y2;
      yhi = (y1 < y2) ? y2 : y1;
      return {(qx == lo) && (qy >= ylo) && (qy <= yhi), 1'b0};
    end
    if (qx < lo || qx > hi) return 2'b00;
    dx  = x2 - x1;
    num = (y1 - qy) * dx + (qx - x1) * (y2 - y1);
    if (num == 0) return 2'b10;
    // half-open x span keeps shared vertices from counting twice
    return {1'b0, (qx < hi) && ((num > 0) == (dx > 0))};
  endfunction

  function automatic pcc_pkg::pcc_out_t polygon_reply(input pcc_pkg::pcc_in_t it);
    pcc_pkg::pcc_out_t r;
    logic [1:0]        h;
    bit                on_edge;
    bit                odd;
    int                j;
    r       = '0;
    on_edge = 1'b0;
    odd     = 1'b0;
    case (it.cmd)
      pcc_pkg::CMD_START: begin
        poly[0].x  = it.px;
        poly[0].y  = it.py;
        poly_len   = 1;
        r.accepted = 1'b1;
      end
      pcc_pkg::CMD_ADD: begin
        if (poly_len < pcc_pkg::MaxVertices) begin
          poly[poly_len].x = it.px;
          poly[poly_len].y = it.py;
          poly_len++;
          r.accepted = 1'b1;
        end
      end
      pcc_pkg::CMD_QUERY: begin
        for (int i = 0; i < poly_len; i++) begin
          j = (i + 1 < poly_len) ? i + 1 : 0;
          h = edge_hits(poly[i], poly[j], $signed(it.px), $signed(it.py));
          on_edge |= h[1];
          odd ^= h[0];
        end
        r.on_boundary = on_edge;
        r.inside_res  = on_edge | odd;
      end
      default: ;
    endcase
    r.vertex_count = pcc_pkg::CountW'(poly_len);
    return r;
  endfunction

  function automatic pcc_pkg::pcc_out_t mk_res(input bit ins, input bit bnd, input bit acc,
                                               input int cnt);
    pcc_pkg::pcc_out_t r;
    r.inside_res   = ins;
    r.on_boundary  = bnd;
    r.accepted     = acc;
    r.vertex_count = pcc_pkg::CountW'(cnt);
    return r;
  endfunction

  function automatic plan_row_t mk_row(input logic [1:0] cmd, input int x, input int y,
                                       input bit typed, input pcc_pkg::pcc_out_t want);
    plan_row_t row;
    row.item.cmd = cmd;
    row.item.px  = 16'(x);
    row.item.py  = 16'(y);
    row.typed    = typed;
    row.want     = want;
    return row;
  endfunction

  function automatic logic [15:0] pick_coord(input span_e span);
    int sel;
    sel = $urandom_range(16);
    if (span == SPAN_SMALL) return 16'(sel - 8);
    if (span == SPAN_FULL) return 16'($urandom);
    case (sel[1:0])
      2'd0:    return 16'h8000;
      2'd1:    return 16'h7fff;
      2'd2:    return 16'hffff;
      default: return 16'h0000;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [6:0] want_v,
                                      input logic [6:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want_v, got_v);
      mismatches++;
    end
  endfunction

  // Present one beat, hold it until taken, then log what it should produce.
  task automatic send_beat(input pcc_pkg::pcc_in_t it, input bit typed,
                           input pcc_pkg::pcc_out_t want);
    pcc_pkg::pcc_out_t model_r;
    int                idle_pct;
    idle_pct = (sent_items < 520) ? 21 : ((sent_items < 1020) ? 83 : 0);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    model_r = polygon_reply(it);
    pending_replies.push_back(typed ? want : model_r);
    if (it.cmd != CmdUnused) sent_items++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: result with nothing expected, got %h", $time, res_o);
        mismatches++;
      end else begin
        reply_r = pending_replies.pop_front();
        check_field("inside_res", 7'(reply_r.inside_res), 7'(res_o.inside_res));
        check_field("on_boundary", 7'(reply_r.on_boundary), 7'(res_o.on_boundary));
        check_field("accepted", 7'(reply_r.accepted), 7'(res_o.accepted));
        check_field("vertex_count", reply_r.vertex_count, res_o.vertex_count);
      end
    end
  end

  initial begin
    pcc_pkg::pcc_in_t it;
    span_e            span;
    int               n_verts, n_q, k, nxt, ox, oy, target, drain;

    rst_ni     = 1'b0;
    start      = 1'b0;
    item_i     = '0;
    poly_len   = 0;
    sent_items = 0;
    mismatches = 0;

    plan.push_back(mk_row(pcc_pkg::CMD_QUERY, 0, 0, 1'b1, mk_res(0, 0, 0, 0)));
    plan.push_back(mk_row(CmdUnused, -1, -1, 1'b1, mk_res(0, 0, 0, 0)));
    plan.push_back(mk_row(pcc_pkg::CMD_ADD, 5, 5, 1'b1, mk_res(0, 0, 1, 1)));
    plan.push_back(mk_row(pcc_pkg::CMD_QUERY, 5, 5, 1'b1, mk_res(1, 1, 0, 1)));
    plan.push_back(mk_row(pcc_pkg::CMD_QUERY, 5, 6, 1'b0, '0));
    plan.push_back(mk_row(pcc_pkg::CMD_START, -32768, -32768, 1'b1, mk_res(0, 0, 1, 1)));
    plan.push_back(mk_row(pcc_pkg::CMD_ADD, 32767, -32768, 1'b1, mk_res(0, 0, 1, 2)));
    plan.push_back(mk_row(pcc_pkg::CMD_QUERY, 0, -32768, 1'b1, mk_res(1, 1, 0, 2)));
    plan.push_back(mk_row(pcc_pkg::CMD_ADD, 32767, 32767, 1'b1, mk_res(0, 0, 1, 3)));
    plan.push_back(mk_row(pcc_pkg::CMD_ADD, -32768, 32767, 1'b1, mk_res(0, 0, 1, 4)));
    plan.push_back(mk_row(pcc_pkg::CMD_QUERY, 0, 0, 1'b0, '0));
    plan.push_back(mk_row(pcc_pkg::CMD_QUERY, -32768, 0, 1'b1, mk_res(1, 1, 0, 4)));
    plan.push_back(mk_row(pcc_pkg::CMD_QUERY, 32767, 32767, 1'b1, mk_res(1, 1, 0, 4)));
    plan.push_back(mk_row(pcc_pkg::CMD_QUERY, -1, 32767, 1'b0, '0));
    plan.push_back(mk_row(CmdUnused, 32767, -32768, 1'b1, mk_res(0, 0, 0, 4)));
    plan.push_back(mk_row(pcc_pkg::CMD_START, 0, 0, 1'b1, mk_res(0, 0, 1, 1)));
    plan.push_back(mk_row(pcc_pkg::CMD_ADD, 10, 0, 1'b1, mk_res(0, 0, 1, 2)));
    plan.push_back(mk_row(pcc_pkg::CMD_QUERY, 5, 1, 1'b0, '0));
    plan.push_back(mk_row(pcc_pkg::CMD_ADD, 0, 10, 1'b1, mk_res(0, 0, 1, 3)));
    plan.push_back(mk_row(pcc_pkg::CMD_QUERY, 2, 2, 1'b0, '0));
    plan.push_back(mk_row(pcc_pkg::CMD_QUERY, 0, 5, 1'b0, '0));
    plan.push_back(mk_row(pcc_pkg::CMD_QUERY, 5, 5, 1'b0, '0));
    plan.push_back(mk_row(pcc_pkg::CMD_QUERY, 10, 10, 1'b0, '0));
    plan.push_back(mk_row(pcc_pkg::CMD_QUERY, -1, 0, 1'b0, '0));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) send_beat(plan[i].item, plan[i].typed, plan[i].want);

    target = sent_items + RandomItems;
    while (sent_items < target) begin
      if ($urandom_range(99) < 15) begin
        // noise: any command, any coordinates
        it.cmd = 2'($urandom_range(3));
        it.px  = 16'($urandom);
        it.py  = 16'($urandom);
        send_beat(it, 1'b0, '0);
      end else begin
        k    = $urandom_range(9);
        span = (k < 7) ? SPAN_SMALL : ((k < 9) ? SPAN_FULL : SPAN_EXTREME);
        n_verts = ($urandom_range(9) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 12);
        for (int v = 0; v < n_verts; v++) begin
          it.cmd = (v == 0) ? pcc_pkg::CMD_START : pcc_pkg::CMD_ADD;
          it.px  = pick_coord(span);
          it.py  = pick_coord(span);
          send_beat(it, 1'b0, '0);
        end
        n_q = $urandom_range(1, 6);
        for (int q = 0; q < n_q; q++) begin
          k      = $urandom_range(poly_len - 1);
          nxt    = (k + 1 < poly_len) ? k + 1 : 0;
          it.cmd = pcc_pkg::CMD_QUERY;
          case ($urandom_range(3))
            0: begin
              it.px = poly[k].x;
              it.py = poly[k].y;
            end
            1: begin
              it.px = 16'((int'($signed(poly[k].x)) + int'($signed(poly[nxt].x))) >>> 1);
              it.py = 16'((int'($signed(poly[k].y)) + int'($signed(poly[nxt].y))) >>> 1);
            end
            2: begin
              it.px = pick_coord(span);
              it.py = pick_coord(span);
            end
            default: begin
              ox = $urandom_range(4);
              oy = $urandom_range(4);
              it.px = 16'(int'($signed(poly[k].x)) + ox - 2);
              it.py = 16'(int'($signed(poly[k].y)) + oy - 2);
            end
          endcase
          send_beat(it, 1'b0, '0);
        end
      end
    end
    start <= 1'b0;

    drain = 0;
    while (pending_replies.size() != 0 && drain < 2000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (SettleCycles) @(posedge clk_i);
    if (pending_replies.size() != 0) begin
      $display("%0t: %0d results expected but never seen", $time, pending_replies.size());
      mismatches++;
    end

    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
